// ===== rtl/sliding_window_click_rate_top_macros.svh =====
// Assertion helpers for the click rate block.
`ifndef SLIDING_WINDOW_CLICK_RATE_TOP_MACROS_SVH
`define SLIDING_WINDOW_CLICK_RATE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define SWCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SWCR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define SWCR_ASSERT(label, prop, msg)

`define SWCR_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

// ===== rtl/swcr_pkg.sv =====
package swcr_pkg;

    localparam int MAX_EVENTS   = 64;
    localparam int TIME_BITS    = 48;
    localparam int WIN_BITS     = 16;
    localparam int RATE_W       = 7;
    localparam int IDX_W        = $clog2(MAX_EVENTS);
    localparam int CNT_W        = $clog2(MAX_EVENTS + 1);
    localparam int NUM_BTN      = 2;
    localparam int QDEPTH       = 2;
    localparam int QIDX_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(1000);

    localparam int BTN_LEFT  = 0;
    localparam int BTN_RIGHT = 1;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic                 left_down;
        logic                 right_down;
    } tick_t;

    typedef struct packed {
        logic [RATE_W-1:0] left_rate;
        logic [RATE_W-1:0] right_rate;
        logic              left_dropped;
        logic              right_dropped;
    } result_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic [TIME_BITS-1:0] cutoff;
        logic                 left_push;
        logic                 right_push;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PRUNE
    } back_state_t;

    function automatic logic [IDX_W-1:0] ptr_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
        if (sum >= (CNT_W+1)'(MAX_EVENTS))
        begin
            sum = sum - (CNT_W+1)'(MAX_EVENTS);
        end
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] nxt;
        if (base == IDX_W'(MAX_EVENTS - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = base + IDX_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/swcr_ram.sv =====
module swcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swcr_front.sv =====
module swcr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [swcr_pkg::WIN_BITS-1:0]  cfg_wdata,
    input  logic                           tick_valid,
    output logic                           tick_stall,
    input  swcr_pkg::tick_t                tick,
    input  logic                           q_full,
    output logic                           q_push,
    output swcr_pkg::cmd_t                 q_cmd
);

    import swcr_pkg::*;

    logic [WIN_BITS-1:0] window_reg;
    logic                prev_left_reg;
    logic                prev_right_reg;
    logic [TIME_BITS-1:0] win_ext;

    assign tick_stall = q_full;
    assign q_push     = tick_valid && !q_full;
    assign win_ext    = TIME_BITS'(window_reg);

    always_comb
    begin
        q_cmd.now_ms     = tick.now_ms;
        q_cmd.cutoff     = (tick.now_ms >= win_ext) ? tick.now_ms - win_ext : '0;
        q_cmd.left_push  = tick.left_down && !prev_left_reg;
        q_cmd.right_push = tick.right_down && !prev_right_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= WINDOW_RESET;
            prev_left_reg  <= 1'b0;
            prev_right_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (q_push)
            begin
                prev_left_reg  <= tick.left_down;
                prev_right_reg <= tick.right_down;
            end
        end
    end

endmodule

// ===== rtl/swcr_cmdq.sv =====
`include "sliding_window_click_rate_top_macros.svh"

module swcr_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  swcr_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output swcr_pkg::cmd_t head_cmd
);

    import swcr_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QIDX_W-1:0] wptr_reg;
    logic [QIDX_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = slot_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == QIDX_W'(QDEPTH - 1)) ? '0 : wptr_reg + QIDX_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == QIDX_W'(QDEPTH - 1)) ? '0 : rptr_reg + QIDX_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    `SWCR_ASSERT(a_q_count_max, count_reg <= QCNT_W'(QDEPTH), "cmd queue overfilled")
    `SWCR_ASSERT_IMPL(a_q_ptr_gap, valid && !full, wptr_reg != rptr_reg, "cmd queue pointer slip")

endmodule

// ===== rtl/swcr_back.sv =====
`include "sliding_window_click_rate_top_macros.svh"

module swcr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  swcr_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            result_valid,
    input  logic            result_stall,
    output swcr_pkg::result_t result
);

    import swcr_pkg::*;

    back_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     head_reg [NUM_BTN];
    logic [IDX_W-1:0]     head_next [NUM_BTN];
    logic [CNT_W-1:0]     fill_reg [NUM_BTN];
    logic [CNT_W-1:0]     fill_next [NUM_BTN];
    logic                 drop_reg [NUM_BTN];
    logic                 drop_next [NUM_BTN];
    logic [TIME_BITS-1:0] cutoff_reg, cutoff_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg, out_data_next;

    logic                 push [NUM_BTN];
    logic                 we [NUM_BTN];
    logic [IDX_W-1:0]     waddr [NUM_BTN];
    logic [TIME_BITS-1:0] rdata [NUM_BTN];
    logic                 pop [NUM_BTN];
    logic                 out_free;
    logic                 prune_done;

    assign push[BTN_LEFT]  = q_cmd.left_push;
    assign push[BTN_RIGHT] = q_cmd.right_push;
    assign out_free        = !out_valid_reg || !result_stall;

    // front stamp is older than cutoff: retire it
    always_comb
    begin
        for (int b = 0; b < NUM_BTN; b++)
        begin
            pop[b] = (state_reg == ST_PRUNE) && (fill_reg[b] != '0) && (rdata[b] < cutoff_reg);
        end
    end

    assign prune_done = !pop[BTN_LEFT] && !pop[BTN_RIGHT];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_PRUNE;
            end
            ST_PRUNE:
            begin
                if (prune_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = (state_reg == ST_IDLE) && q_valid;
        cutoff_next    = cutoff_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && result_stall;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            head_next[b] = head_reg[b];
            fill_next[b] = fill_reg[b];
            drop_next[b] = drop_reg[b];
            we[b]        = 1'b0;
            waddr[b]     = ptr_add(head_reg[b], fill_reg[b]);
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cutoff_next = q_cmd.cutoff;
                    for (int b = 0; b < NUM_BTN; b++)
                    begin
                        we[b]        = push[b] && (fill_reg[b] != CNT_W'(MAX_EVENTS));
                        drop_next[b] = push[b] && (fill_reg[b] == CNT_W'(MAX_EVENTS));
                        if (we[b])
                        begin
                            fill_next[b] = fill_reg[b] + CNT_W'(1);
                        end
                    end
                end
            end
            ST_READ:
            begin
            end
            ST_PRUNE:
            begin
                for (int b = 0; b < NUM_BTN; b++)
                begin
                    if (pop[b])
                    begin
                        head_next[b] = ptr_inc(head_reg[b]);
                        fill_next[b] = fill_reg[b] - CNT_W'(1);
                    end
                end
                if (prune_done && out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.left_rate     = RATE_W'(fill_reg[BTN_LEFT]);
                    out_data_next.right_rate    = RATE_W'(fill_reg[BTN_RIGHT]);
                    out_data_next.left_dropped  = drop_reg[BTN_LEFT];
                    out_data_next.right_dropped = drop_reg[BTN_RIGHT];
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar g = 0; g < NUM_BTN; g++)
    begin : g_store
        swcr_ram #(
            .WIDTH (TIME_BITS),
            .DEPTH (MAX_EVENTS)
        ) u_stamps (
            .clk   (clk),
            .we    (we[g]),
            .waddr (waddr[g]),
            .wdata (q_cmd.now_ms),
            .raddr (head_next[g]),
            .rdata (rdata[g])
        );
    end

    always_ff @(posedge clk)
    begin
        cutoff_reg   <= cutoff_next;
        out_data_reg <= out_data_next;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            drop_reg[b] <= drop_next[b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BTN; b++)
            begin
                head_reg[b] <= '0;
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int b = 0; b < NUM_BTN; b++)
            begin
                head_reg[b] <= head_next[b];
                fill_reg[b] <= fill_next[b];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `SWCR_ASSERT(a_fill_left_max, fill_reg[BTN_LEFT] <= CNT_W'(MAX_EVENTS), "left store overfilled")
    `SWCR_ASSERT(a_fill_right_max, fill_reg[BTN_RIGHT] <= CNT_W'(MAX_EVENTS), "right store overfilled")
    `SWCR_ASSERT_IMPL(a_out_from_prune, $rose(out_valid_reg), $past(state_reg == ST_PRUNE), "result without prune")
    `SWCR_ASSERT_IMPL(a_take_when_idle, q_pop, state_reg == ST_IDLE, "command taken mid-item")

endmodule

// ===== rtl/sliding_window_click_rate_top.sv =====
// The back pops a tick in ST_IDLE, reads in ST_READ and prunes one stamp per button per cycle
// in ST_PRUNE; it takes no new tick until the result of the last one is registered.
// A two-entry command queue lets the front take ticks while the back prunes.
// Reset (rst_n, async, active low): stores empty, buttons released, window 1000 ms.
// Stamp memories are not cleared; only entries inside the fill count are read.
module sliding_window_click_rate_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swcr_pkg::WIN_BITS-1:0] cfg_wdata,
    input  logic                          tick_valid,
    output logic                          tick_stall,
    input  swcr_pkg::tick_t               tick,
    output logic                          result_valid,
    input  logic                          result_stall,
    output swcr_pkg::result_t             result
);

    import swcr_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_head_cmd;

    swcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd)
    );

    swcr_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (q_head_cmd)
    );

    swcr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_head_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== sim/swcr_rate_checker.sv =====
module swcr_rate_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swcr_pkg::WIN_BITS-1:0] cfg_wdata,
    input  logic                          tick_valid,
    input  logic                          tick_stall,
    input  swcr_pkg::tick_t               tick,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  swcr_pkg::result_t             result,
    output int                            mismatches,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import swcr_pkg::*;

    localparam int EXP_DEPTH = 16;

    logic [TIME_BITS-1:0] stamp_log [NUM_BTN][MAX_EVENTS];
    int unsigned          log_head  [NUM_BTN];
    int unsigned          log_fill  [NUM_BTN];
    logic [NUM_BTN-1:0]   prev_level;
    logic [WIN_BITS-1:0]  window;
    result_t              exp_ring  [EXP_DEPTH];
    int unsigned          exp_rd;
    int unsigned          exp_wr;
    int unsigned          exp_count;

    task automatic report(input string msg);
        $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // push on rising edge, then pop stamps older than the cutoff
    task automatic predict_rates(input tick_t t);
        logic [NUM_BTN-1:0]   level;
        logic [NUM_BTN-1:0]   lost;
        logic [TIME_BITS-1:0] cutoff;
        result_t              r;
        level[BTN_LEFT]  = t.left_down;
        level[BTN_RIGHT] = t.right_down;
        lost = '0;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            if (level[b] && !prev_level[b])
            begin
                if (log_fill[b] >= MAX_EVENTS)
                begin
                    lost[b] = 1'b1;
                end
                else
                begin
                    stamp_log[b][(log_head[b] + log_fill[b]) % MAX_EVENTS] = t.now_ms;
                    log_fill[b]++;
                end
            end
        end
        prev_level = level;
        cutoff = (t.now_ms >= TIME_BITS'(window)) ? t.now_ms - TIME_BITS'(window) : '0;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            while (log_fill[b] > 0 && stamp_log[b][log_head[b]] < cutoff)
            begin
                log_head[b] = (log_head[b] + 1) % MAX_EVENTS;
                log_fill[b]--;
            end
        end
        r.left_rate     = RATE_W'(log_fill[BTN_LEFT]);
        r.right_rate    = RATE_W'(log_fill[BTN_RIGHT]);
        r.left_dropped  = lost[BTN_LEFT];
        r.right_dropped = lost[BTN_RIGHT];
        if (exp_count == EXP_DEPTH)
        begin
            report("too many result beats outstanding");
        end
        else
        begin
            exp_ring[exp_wr] = r;
            exp_wr = (exp_wr + 1) % EXP_DEPTH;
            exp_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BTN; b++)
            begin
                log_head[b] = 0;
                log_fill[b] = 0;
            end
            prev_level = '0;
            window     = WINDOW_RESET;
            exp_rd     = 0;
            exp_wr     = 0;
            exp_count  = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                window = cfg_wdata;
            end
            if (tick_valid && !tick_stall)
            begin
                predict_rates(tick);
            end
            if (result_valid && !result_stall)
            begin
                if (exp_count == 0)
                begin
                    report("result beat with no tick outstanding");
                end
                else
                begin
                    want = exp_ring[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    if (result.left_rate !== want.left_rate)
                    begin
                        report($sformatf("left_rate expected %0d got %0d",
                                         want.left_rate, result.left_rate));
                    end
                    if (result.right_rate !== want.right_rate)
                    begin
                        report($sformatf("right_rate expected %0d got %0d",
                                         want.right_rate, result.right_rate));
                    end
                    if (result.left_dropped !== want.left_dropped)
                    begin
                        report($sformatf("left_dropped expected %0b got %0b",
                                         want.left_dropped, result.left_dropped));
                    end
                    if (result.right_dropped !== want.right_dropped)
                    begin
                        report($sformatf("right_dropped expected %0b got %0b",
                                         want.right_dropped, result.right_dropped));
                    end
                end
            end
        end
        pending = int'(exp_count);
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swcr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [WIN_BITS-1:0]  cfg_wdata    = '0;
    logic                 tick_valid   = 1'b0;
    logic                 tick_stall;
    tick_t                tick         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    int                   mismatches;
    int                   pending;
    int                   cycle_count  = 0;
    logic                 calm         = 1'b0;
    logic [TIME_BITS-1:0] clock_ms     = '0;
    logic                 left_level   = 1'b0;
    logic                 right_level  = 1'b0;

    always #1 clk = ~clk;

    sliding_window_click_rate_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    swcr_rate_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always @(negedge clk)
    begin
        result_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // called and returns at a falling edge; valid stays high after the beat
    task automatic send_tick(input logic [TIME_BITS-1:0] stamp, input logic l,
                             input logic r);
        if (!calm)
        begin
            while ($urandom_range(99) < 13)
            begin
                tick_valid <= 1'b0;
                @(negedge clk);
            end
        end
        tick_valid <= 1'b1;
        tick       <= '{now_ms: stamp, left_down: l, right_down: r};
        do
        begin
            @(posedge clk);
        end
        while (tick_stall);
        @(negedge clk);
    endtask

    task automatic write_window(input logic [WIN_BITS-1:0] w);
        tick_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [WIN_BITS-1:0] w, input int unsigned step_max,
                             input int unsigned noise, input int count);
        int unsigned roll;
        write_window(w);
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < noise / 2)
            begin
                clock_ms    = TIME_BITS'({$urandom(), $urandom()});
                left_level  = 1'($urandom_range(1));
                right_level = 1'($urandom_range(1));
            end
            else if (roll < noise)
            begin
                clock_ms = clock_ms - TIME_BITS'($urandom_range(100));
            end
            else if (noise != 0 && roll < noise + 3)
            begin
                clock_ms = clock_ms + TIME_BITS'($urandom_range(4 * w + 16));
            end
            else
            begin
                clock_ms = clock_ms + TIME_BITS'($urandom_range(step_max));
                if ($urandom_range(1) == 1)
                begin
                    left_level = ~left_level;
                end
                if ($urandom_range(1) == 1)
                begin
                    right_level = ~right_level;
                end
            end
            send_tick(clock_ms, left_level, right_level);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // window at its reset value
        send_tick(TIME_BITS'(0), 1'b1, 1'b1);
        send_tick(TIME_BITS'(0), 1'b0, 1'b0);
        send_tick(TIME_BITS'(500), 1'b1, 1'b0);
        send_tick(TIME_BITS'(999), 1'b1, 1'b1);
        send_tick(TIME_BITS'(1000), 1'b0, 1'b0);
        send_tick(TIME_BITS'(1001), 1'b0, 1'b0);
        send_tick(TIME_BITS'(2000), 1'b0, 1'b0);
        send_tick(TIME_BITS'(100), 1'b1, 1'b0);
        send_tick(TIME_MAX, 1'b0, 1'b1);
        send_tick(TIME_MAX, 1'b1, 1'b0);
        send_tick(TIME_BITS'(0), 1'b0, 1'b0);

        // zero window: cutoff equals now, a press at now is kept
        write_window('0);
        send_tick(TIME_BITS'(10), 1'b1, 1'b0);
        send_tick(TIME_BITS'(10), 1'b0, 1'b1);
        send_tick(TIME_BITS'(11), 1'b1, 1'b1);
        send_tick(TIME_BITS'(11), 1'b0, 1'b0);
        send_tick(TIME_BITS'(12), 1'b1, 1'b1);
        clock_ms    = TIME_BITS'(12);
        left_level  = 1'b1;
        right_level = 1'b1;

        run_phase('1, 16, 0, 380);
        run_phase(WIN_BITS'(1), 3, 13, 140);
        run_phase('0, 2, 13, 120);
        calm = 1'b1;
        run_phase(WIN_BITS'(1000), 40, 13, 160);
        calm = 1'b0;
        run_phase(WIN_BITS'($urandom_range(65535, 2)), 300, 13, 160);
        run_phase(WIN_BITS'(300), 8, 13, 140);

        tick_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (80) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
